FILE: rtl/gru_pkg.sv
// shared types and constants of the glyph record unpacker
`timescale 1ns / 1ps

package gru_pkg;

   localparam int INDEX_WIDTH_DEFAULT = 24;
   localparam int HEADER_WIDTH        = 48;
   localparam int RSP_DATA_WIDTH      = 80;
   localparam int CSR_ADDR_WIDTH      = 5;

   localparam logic [5:0] HEADER_DONE = 6'd48;

   localparam logic [2:0] REG_ADVANCE_BITS    = 3'd0;
   localparam logic [2:0] REG_OFFSET_BITS     = 3'd1;
   localparam logic [2:0] REG_SIZE_BITS       = 3'd2;
   localparam logic [2:0] REG_ADVANCE_FRAC    = 3'd3;
   localparam logic [2:0] REG_DEFAULT_ADVANCE = 3'd4;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_BITMAP = 1'b1;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] advance_width;
      logic [7:0]  offset_x;
      logic [7:0]  offset_y;
      logic [7:0]  box_width;
      logic [7:0]  box_height;
      logic [23:0] bmp_index;
      logic [7:0]  bitmap_byte;
      logic        run_last;
   } result_type;

endpackage

FILE: rtl/glyph_record_unpacker_unit.sv
// glyph record unpacker: bit-packed font glyph records in, headers and bitmap bytes out
//
// req channel carries one record byte per transaction, bits used msb first, with
// tuser marking bytes of glyph zero and tlast marking the final byte of a record.
// rsp channel carries results: tuser 0 is a glyph header (advance, offsets, box,
// bitmap index), tuser 1 is one realigned bitmap byte; tlast marks the last result
// caused by one req transaction. one req byte gives zero, one or two results.
// results are computed in the cycle a byte is taken and land in a two-entry result
// buffer, so the first result of a byte is visible in the cycle after the byte.
// throughput is one byte per cycle while rsp_tready stays high and each byte gives
// at most one result; a byte giving two results holds req_tready low while both
// are buffered. req_tready depends on the fill of the result buffer and on rsp_tready.
// when the receiver stalls, the buffer holds its results and req_tready drops.
// csr port is apb style, pready always high, registers at byte address 4*i.
// reset clears the record state, the bitmap index and the result buffer, and
// returns the registers to advance_bits 0, offset_bits 8, size_bits 8,
// advance_fractional 0 and default_advance 0.
`timescale 1ns / 1ps

module glyph_record_unpacker_unit
   import gru_pkg::*;
#(
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // record_byte
   input  logic                      req_tuser,   // first_glyph
   input  logic                      req_tlast,   // record_end
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // advance_width[15:0] offset_x[23:16] offset_y[31:24] box_width[39:32]
   // box_height[47:40] bmp_index[71:48] bitmap_byte[79:72]
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tuser,   // result_kind
   output logic                      rsp_tlast,   // run_last
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   // configuration registers
   logic [4:0]  adv_bits_ff;
   logic [3:0]  ofs_bits_ff;
   logic [3:0]  size_bits_ff;
   logic        adv_frac_ff;
   logic [15:0] def_adv_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   // record state
   logic [7:0]              res_ff, res_in;
   logic [3:0]              rcnt_ff, rcnt_in;
   logic [HEADER_WIDTH-1:0] shift_ff, shift_in;
   logic [5:0]              hbs_ff, hbs_in;
   logic [INDEX_WIDTH-1:0]  index_ff, index_in;
   logic                    wanted_ff, wanted_in;
   logic                    open_ff, open_in;

   // result buffer
   result_type slot_a_ff, slot_a_in;
   result_type slot_b_ff, slot_b_in;
   logic [1:0] count_ff, count_in;

   // datapath
   logic                    accept;
   logic                    take_out;
   logic [INDEX_WIDTH-1:0]  st_index;
   logic [HEADER_WIDTH-1:0] st_shift;
   logic [5:0]              st_hbs;
   logic [7:0]              st_res;
   logic [3:0]              st_rcnt;
   logic                    st_wanted;
   logic [4:0]              ea;
   logic [3:0]              eo;
   logic [3:0]              es;
   logic [5:0]              nb;
   logic [5:0]              diff;
   logic [3:0]              take;
   logic [3:0]              left;
   logic [2:0]              c;
   logic [HEADER_WIDTH-1:0] new_shift;
   logic [HEADER_WIDTH-1:0] short_shift;
   logic [HEADER_WIDTH-1:0] hdr_src;
   logic [5:0]              new_hbs;
   logic [5:0]              adv_pos;
   logic [5:0]              ox_pos;
   logic [5:0]              oy_pos;
   logic [15:0]             adv_mask;
   logic [7:0]              ofs_mask;
   logic [7:0]              size_mask;
   logic [15:0]             adv_raw;
   logic [15:0]             adv_val;
   logic [7:0]              ox_raw;
   logic [7:0]              oy_raw;
   logic [7:0]              ox_val;
   logic [7:0]              oy_val;
   logic [7:0]              bw_val;
   logic [7:0]              bh_val;
   logic                    wanted_h;
   logic [INDEX_WIDTH-1:0]  idx_run;
   result_type              hdr_item;
   result_type              item;
   result_type              r0;
   result_type              r1;
   logic [1:0]              n;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         adv_bits_ff  <= 5'd0;
         ofs_bits_ff  <= 4'd8;
         size_bits_ff <= 4'd8;
         adv_frac_ff  <= 1'b0;
         def_adv_ff   <= 16'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ADVANCE_BITS:    adv_bits_ff  <= csr_pwdata[4:0];
            REG_OFFSET_BITS:     ofs_bits_ff  <= csr_pwdata[3:0];
            REG_SIZE_BITS:       size_bits_ff <= csr_pwdata[3:0];
            REG_ADVANCE_FRAC:    adv_frac_ff  <= csr_pwdata[0];
            REG_DEFAULT_ADVANCE: def_adv_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ADVANCE_BITS:    csr_prdata = {27'd0, adv_bits_ff};
         REG_OFFSET_BITS:     csr_prdata = {28'd0, ofs_bits_ff};
         REG_SIZE_BITS:       csr_prdata = {28'd0, size_bits_ff};
         REG_ADVANCE_FRAC:    csr_prdata = {31'd0, adv_frac_ff};
         REG_DEFAULT_ADVANCE: csr_prdata = {16'd0, def_adv_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // handshakes
   assign rsp_tvalid = (count_ff != 2'd0);
   assign req_tready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready);
   assign accept     = req_tvalid & req_tready;
   assign take_out   = rsp_tvalid & rsp_tready;

   assign rsp_tuser = slot_a_ff.result_kind;
   assign rsp_tlast = slot_a_ff.run_last;
   assign rsp_tdata = {slot_a_ff.bitmap_byte, slot_a_ff.bmp_index,
                       slot_a_ff.box_height, slot_a_ff.box_width,
                       slot_a_ff.offset_y, slot_a_ff.offset_x,
                       slot_a_ff.advance_width};

   // field widths and header layout
   always_comb begin
      ea = (adv_bits_ff > 5'd16) ? 5'd16 : adv_bits_ff;
      eo = (ofs_bits_ff == 4'd0) ? 4'd1 : ((ofs_bits_ff > 4'd8) ? 4'd8 : ofs_bits_ff);
      es = (size_bits_ff == 4'd0) ? 4'd1 : ((size_bits_ff > 4'd8) ? 4'd8 : size_bits_ff);
      nb = 6'(ea) + 6'({eo, 1'b0}) + 6'({es, 1'b0});
      oy_pos  = 6'({es, 1'b0});
      ox_pos  = 6'({es, 1'b0}) + 6'(eo);
      adv_pos = 6'({es, 1'b0}) + 6'({eo, 1'b0});
      adv_mask  = 16'((17'd1 << ea) - 17'd1);
      ofs_mask  = 8'((9'd1 << eo) - 9'd1);
      size_mask = 8'((9'd1 << es) - 9'd1);
   end

   // record datapath
   always_comb begin
      st_index  = (!open_ff && req_tuser) ? '0 : index_ff;
      st_shift  = open_ff ? shift_ff : '0;
      st_hbs    = open_ff ? hbs_ff : 6'd0;
      st_res    = open_ff ? res_ff : 8'd0;
      st_rcnt   = open_ff ? rcnt_ff : 4'd0;
      st_wanted = open_ff ? wanted_ff : 1'b0;

      take = 4'd0;
      diff = nb - st_hbs;
      if (st_hbs < nb) begin
         take = (diff > 6'd8) ? 4'd8 : diff[3:0];
      end
      left        = 4'd8 - take;
      new_shift   = (st_shift << take) | HEADER_WIDTH'(req_tdata >> left);
      new_hbs     = st_hbs + 6'(take);
      short_shift = new_shift << (nb - new_hbs);
      hdr_src     = (new_hbs >= nb) ? new_shift : short_shift;

      adv_raw = (ea == 5'd0) ? def_adv_ff : (16'(hdr_src >> adv_pos) & adv_mask);
      adv_val = adv_frac_ff ? adv_raw : {adv_raw[11:0], 4'b0000};
      ox_raw  = 8'(hdr_src >> ox_pos) & ofs_mask;
      oy_raw  = 8'(hdr_src >> oy_pos) & ofs_mask;
      ox_val  = ox_raw[3'(eo - 4'd1)] ? (ox_raw | ~ofs_mask) : ox_raw;
      oy_val  = oy_raw[3'(eo - 4'd1)] ? (oy_raw | ~ofs_mask) : oy_raw;
      bw_val  = 8'(hdr_src >> es) & size_mask;
      bh_val  = 8'(hdr_src) & size_mask;
      wanted_h = !req_tuser && (bw_val != 8'd0) && (bh_val != 8'd0);

      hdr_item = '0;
      hdr_item.result_kind = KIND_HEADER;
      hdr_item.bmp_index   = 24'(st_index);
      if (!req_tuser) begin
         hdr_item.advance_width = adv_val;
         hdr_item.offset_x      = ox_val;
         hdr_item.offset_y      = oy_val;
         hdr_item.box_width     = bw_val;
         hdr_item.box_height    = bh_val;
      end

      c         = st_rcnt[2:0];
      idx_run   = st_index;
      n         = 2'd0;
      r0        = '0;
      r1        = '0;
      item      = '0;
      shift_in  = st_shift;
      hbs_in    = st_hbs;
      res_in    = st_res;
      rcnt_in   = st_rcnt;
      wanted_in = st_wanted;

      if (st_hbs < HEADER_DONE) begin
         if (new_hbs >= nb) begin
            r0        = hdr_item;
            n         = 2'd1;
            shift_in  = new_shift;
            hbs_in    = HEADER_DONE;
            wanted_in = wanted_h;
            res_in    = req_tdata & 8'((9'd1 << left) - 9'd1);
            rcnt_in   = left;
            if (left == 4'd8) begin
               if (wanted_h) begin
                  r1 = '0;
                  r1.result_kind = KIND_BITMAP;
                  r1.bmp_index   = 24'(idx_run);
                  r1.bitmap_byte = req_tdata;
                  idx_run = idx_run + INDEX_WIDTH'(1);
                  n = 2'd2;
               end
               res_in  = 8'd0;
               rcnt_in = 4'd0;
            end
         end else if (req_tlast) begin
            r0        = hdr_item;
            n         = 2'd1;
            shift_in  = short_shift;
            hbs_in    = HEADER_DONE;
            wanted_in = 1'b0;
            rcnt_in   = 4'd0;
         end else begin
            shift_in = new_shift;
            hbs_in   = new_hbs;
         end
      end else begin
         res_in  = req_tdata & 8'((9'd1 << c) - 9'd1);
         rcnt_in = 4'(c);
         if (st_wanted) begin
            r0 = '0;
            r0.result_kind = KIND_BITMAP;
            r0.bmp_index   = 24'(idx_run);
            r0.bitmap_byte = (st_res << (4'd8 - 4'(c))) | (req_tdata >> c);
            idx_run = idx_run + INDEX_WIDTH'(1);
            n = 2'd1;
         end
      end

      // leftover bits close the record
      if (req_tlast && (rcnt_in != 4'd0) && (rcnt_in < 4'd8) && wanted_in) begin
         item = '0;
         item.result_kind = KIND_BITMAP;
         item.bmp_index   = 24'(idx_run);
         item.bitmap_byte = res_in << (4'd8 - rcnt_in);
         idx_run = idx_run + INDEX_WIDTH'(1);
         if (n == 2'd0) begin
            r0 = item;
         end else begin
            r1 = item;
         end
         n = n + 2'd1;
      end

      if (n == 2'd1) begin
         r0.run_last = 1'b1;
      end else if (n == 2'd2) begin
         r1.run_last = 1'b1;
      end

      index_in = idx_run;
      open_in  = !req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff    <= 8'd0;
         rcnt_ff   <= 4'd0;
         shift_ff  <= '0;
         hbs_ff    <= 6'd0;
         index_ff  <= '0;
         wanted_ff <= 1'b0;
         open_ff   <= 1'b0;
      end else if (accept) begin
         res_ff    <= res_in;
         rcnt_ff   <= rcnt_in;
         shift_ff  <= shift_in;
         hbs_ff    <= hbs_in;
         index_ff  <= index_in;
         wanted_ff <= wanted_in;
         open_ff   <= open_in;
      end
   end

   // result buffer
   always_comb begin
      slot_a_in = slot_a_ff;
      slot_b_in = slot_b_ff;
      count_in  = count_ff;
      if (accept) begin
         slot_a_in = r0;
         slot_b_in = r1;
         count_in  = n;
      end else if (take_out) begin
         slot_a_in = slot_b_ff;
         count_in  = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_a_ff <= slot_a_in;
      slot_b_ff <= slot_b_in;
   end

   // checks
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !slot_a_ff.run_last && slot_b_ff.run_last)
      else $error("two buffered results without run_last on the second only");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !req_tready)
      else $error("req_tready high with a full result buffer");

   a_hbs_range: assert property (@(posedge clock) disable iff (reset)
      hbs_ff <= HEADER_DONE)
      else $error("header bit count beyond done mark");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      take_out && count_ff == 2'd1 && !accept |=> !rsp_tvalid)
      else $error("result reappears after the buffer drained");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> !open_ff)
      else $error("record still open after its last byte");

endmodule

FILE: tb/glyph_record_unpacker_unit_tb.sv
// testbench of the glyph record unpacker: directed and random glyph records checked against a predictor
`timescale 1ns / 1ps

module glyph_record_unpacker_unit_tb
   import gru_pkg::*;
();

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 6;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;
   logic                      req_tuser;
   logic                      req_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0]               csr_pwdata;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   // register copy
   logic [4:0]  cfg_advance_bits = 5'd0;
   logic [3:0]  cfg_offset_bits  = 4'd8;
   logic [3:0]  cfg_size_bits    = 4'd8;
   logic        cfg_advance_frac = 1'b0;
   logic [15:0] cfg_default_adv  = 16'd0;

   // glyph decoding state
   logic [7:0]  residue_bits    = 8'd0;
   int unsigned residue_count   = 0;
   logic [47:0] header_bits_in  = 48'd0;
   int unsigned header_seen     = 0;
   logic [23:0] glyph_index     = 24'd0;
   logic        bitmap_on       = 1'b0;
   logic        record_active   = 1'b0;

   result_type  glyph_results_due[$];
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          send_gap_pct   = 0;
   int          rsp_stall_pct  = 0;

   glyph_record_unpacker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------- predictor ----------------

   function automatic int unsigned adv_field_bits();
      return (cfg_advance_bits > 5'd16) ? 16 : int'(cfg_advance_bits);
   endfunction

   function automatic int unsigned clamp_field_bits(logic [3:0] v);
      if (v == 4'd0) return 1;
      if (v > 4'd8) return 8;
      return int'(v);
   endfunction

   function automatic int unsigned header_length();
      return adv_field_bits() + 2 * clamp_field_bits(cfg_offset_bits)
             + 2 * clamp_field_bits(cfg_size_bits);
   endfunction

   function automatic logic [31:0] header_field(int unsigned pos, int unsigned n);
      logic [63:0] wide;
      wide = {16'd0, header_bits_in} >> pos;
      return 32'(wide & ((64'd1 << n) - 64'd1));
   endfunction

   function automatic logic [7:0] sign_extend_field(logic [7:0] raw, int unsigned n);
      logic [7:0] v;
      v = raw;
      if (v[n-1]) v = v | (8'hFF << n);
      return v;
   endfunction

   function automatic result_type make_header_result(logic glyph_zero);
      result_type  r;
      int unsigned ab, ob, sb, pos;
      logic [31:0] adv;
      logic [7:0]  ox, oy, bw, bh;
      ab  = adv_field_bits();
      ob  = clamp_field_bits(cfg_offset_bits);
      sb  = clamp_field_bits(cfg_size_bits);
      pos = ab + 2 * ob + 2 * sb;
      if (ab != 0) begin
         pos -= ab;
         adv = header_field(pos, ab);
      end else begin
         adv = {16'd0, cfg_default_adv};
      end
      if (!cfg_advance_frac) adv = (adv * 16) & 32'hFFFF;
      pos -= ob;
      ox = sign_extend_field(8'(header_field(pos, ob)), ob);
      pos -= ob;
      oy = sign_extend_field(8'(header_field(pos, ob)), ob);
      pos -= sb;
      bw = 8'(header_field(pos, sb));
      pos -= sb;
      bh = 8'(header_field(pos, sb));
      if (glyph_zero) begin
         adv = '0;
         ox  = '0;
         oy  = '0;
         bw  = '0;
         bh  = '0;
      end
      bitmap_on = !glyph_zero && bw != 0 && bh != 0;
      r = '0;
      r.result_kind   = KIND_HEADER;
      r.advance_width = adv[15:0];
      r.offset_x      = ox;
      r.offset_y      = oy;
      r.box_width     = bw;
      r.box_height    = bh;
      r.bmp_index     = glyph_index;
      return r;
   endfunction

   function automatic result_type make_bitmap_result(logic [7:0] value);
      result_type r;
      r = '0;
      r.result_kind = KIND_BITMAP;
      r.bmp_index   = glyph_index;
      r.bitmap_byte = value;
      glyph_index   = glyph_index + 24'd1;
      return r;
   endfunction

   task automatic predict_glyph_results(input logic [7:0] b, input logic first,
                                        input logic last);
      result_type  outs[2];
      int          n;
      int unsigned nb, take, left, c;
      logic [7:0]  val;
      n = 0;
      if (!record_active) begin
         record_active = 1'b1;
         if (first) glyph_index = 24'd0;
         header_bits_in = 48'd0;
         header_seen    = 0;
         residue_bits   = 8'd0;
         residue_count  = 0;
         bitmap_on      = 1'b0;
      end
      nb = header_length();
      if (header_seen < 48) begin
         take = 0;
         if (header_seen < nb) begin
            take = nb - header_seen;
            if (take > 8) take = 8;
            header_bits_in = (header_bits_in << take) | 48'(b >> (8 - take));
            header_seen += take;
         end
         if (header_seen >= nb) begin
            left = 8 - take;
            outs[n] = make_header_result(first);
            n++;
            header_seen   = 48;
            residue_bits  = b & 8'((1 << left) - 1);
            residue_count = left;
            if (residue_count == 8) begin
               if (bitmap_on) begin
                  outs[n] = make_bitmap_result(residue_bits);
                  n++;
               end
               residue_bits  = 8'd0;
               residue_count = 0;
            end
         end else if (last) begin
            header_bits_in = header_bits_in << (nb - header_seen);
            outs[n] = make_header_result(first);
            n++;
            bitmap_on     = 1'b0;
            header_seen   = 48;
            residue_count = 0;
         end
      end else begin
         c   = residue_count & 7;
         val = (residue_bits << (8 - c)) | (b >> c);
         residue_bits  = b & 8'((1 << c) - 1);
         residue_count = c;
         if (bitmap_on) begin
            outs[n] = make_bitmap_result(val);
            n++;
         end
      end
      if (last) begin
         if (residue_count > 0 && residue_count < 8 && bitmap_on) begin
            outs[n] = make_bitmap_result(residue_bits << (8 - residue_count));
            n++;
         end
         record_active = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
         outs[i].run_last = (i == n - 1);
         glyph_results_due.push_back(outs[i]);
      end
   endtask

   // ---------------- result checking ----------------

   task automatic compare_field(input string name, input logic [31:0] expected,
                                input logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (glyph_results_due.size() == 0) begin
            $error("result transaction with none expected: kind %0d data %h",
                   rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = glyph_results_due.pop_front();
            compare_field("result_kind", 32'(want.result_kind), 32'(rsp_tuser));
            compare_field("advance_width", 32'(want.advance_width),
                          32'(rsp_tdata[15:0]));
            compare_field("offset_x", 32'(want.offset_x), 32'(rsp_tdata[23:16]));
            compare_field("offset_y", 32'(want.offset_y), 32'(rsp_tdata[31:24]));
            compare_field("box_width", 32'(want.box_width), 32'(rsp_tdata[39:32]));
            compare_field("box_height", 32'(want.box_height), 32'(rsp_tdata[47:40]));
            compare_field("bmp_index", 32'(want.bmp_index), 32'(rsp_tdata[71:48]));
            compare_field("bitmap_byte", 32'(want.bitmap_byte), 32'(rsp_tdata[79:72]));
            compare_field("run_last", 32'(want.run_last), 32'(rsp_tlast));
         end
      end
   end

   // ---------------- drivers ----------------

   task automatic send_glyph_byte(input logic [7:0] b, input logic first, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_glyph_results(b, first, last);
   endtask

   // bytes go out from the top of content down
   task automatic send_record_bytes(input logic [63:0] content, input int len,
                                    input logic first, input logic close);
      for (int i = 0; i < len; i++) begin
         send_glyph_byte(content[8*(len-1-i) +: 8], first, close && (i == len - 1));
      end
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (glyph_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_ADVANCE_BITS:    cfg_advance_bits = value[4:0];
         REG_OFFSET_BITS:     cfg_offset_bits  = value[3:0];
         REG_SIZE_BITS:       cfg_size_bits    = value[3:0];
         REG_ADVANCE_FRAC:    cfg_advance_frac = value[0];
         REG_DEFAULT_ADVANCE: cfg_default_adv  = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_all_registers(input int adv_bits, input int ofs_bits, input int size_bits,
                                    input int frac, input int def_adv);
      wait_results_drained();
      write_register(REG_ADVANCE_BITS, adv_bits);
      write_register(REG_OFFSET_BITS, ofs_bits);
      write_register(REG_SIZE_BITS, size_bits);
      write_register(REG_ADVANCE_FRAC, frac);
      write_register(REG_DEFAULT_ADVANCE, def_adv);
   endtask

   // ---------------- tests ----------------

   task automatic test_reset_layout_records();
      send_gap_pct  = 20;
      rsp_stall_pct = 20;
      // glyph zero, then a normal glyph, empty box, short record, header only
      send_record_bytes(64'hFF_FF_05_05_AA, 5, 1'b1, 1'b1);
      send_record_bytes(64'h80_7F_03_02_FF_00_5A, 7, 1'b0, 1'b1);
      send_record_bytes(64'h01_01_00_04_33, 5, 1'b0, 1'b1);
      send_record_bytes(64'h12_34, 2, 1'b0, 1'b1);
      send_record_bytes(64'h01_02_03_04, 4, 1'b0, 1'b1);
   endtask

   task automatic test_register_extremes();
      set_all_registers(16, 8, 8, 1, 'hFFFF);
      send_record_bytes({$urandom, $urandom}, 8, 1'b0, 1'b1);
      set_all_registers(0, 1, 1, 0, 'hFFFF);
      send_record_bytes(64'hFF_A5_3C, 3, 1'b0, 1'b1);
      set_all_registers(31, 15, 15, 0, 'h1234);
      send_record_bytes({$urandom, $urandom}, 7, 1'b0, 1'b1);
      set_all_registers(0, 0, 0, 1, 'h1234);
      send_record_bytes(64'hF0_0F_FF_81, 4, 1'b0, 1'b1);
      set_all_registers(5, 3, 4, 0, 'h0007);
      send_record_bytes(64'h7B_DF_FE_C3_99, 5, 1'b0, 1'b1);
   endtask

   task automatic test_midrecord_register_change();
      // header shrinks below the bits already gathered
      set_all_registers(16, 8, 8, 0, 0);
      send_record_bytes(64'h12_F3_E7, 3, 1'b0, 1'b0);
      wait_results_drained();
      write_register(REG_ADVANCE_BITS, 4);
      write_register(REG_OFFSET_BITS, 1);
      write_register(REG_SIZE_BITS, 1);
      send_record_bytes(64'hC6_5A_81, 3, 1'b0, 1'b1);
      // header shrinks but stays above the bits gathered
      set_all_registers(16, 8, 8, 1, 'h00AB);
      send_record_bytes(64'hFE_DC, 2, 1'b0, 1'b0);
      wait_results_drained();
      write_register(REG_ADVANCE_BITS, 0);
      send_record_bytes(64'h11_FF_03_03_E1_5F, 6, 1'b0, 1'b1);
   endtask

   task automatic test_random_records(input int gap_pct, input int stall_pct, input int n_items);
      int          sent;
      int unsigned hdr_bytes;
      int          len;
      logic        first;
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(11) == 0) begin
            set_all_registers(($urandom_range(4) == 0) ? $urandom_range(17, 31)
                                                       : $urandom_range(0, 16),
                              ($urandom_range(4) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 8),
                              ($urandom_range(4) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 8),
                              $urandom_range(1), $urandom_range('hFFFF));
         end
         hdr_bytes = (header_length() + 7) / 8;
         if ($urandom_range(99) < 85) begin
            first = ($urandom_range(9) == 0);
            len   = hdr_bytes + $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
               send_glyph_byte(8'($urandom_range(255)), first, i == len - 1);
            end
         end else begin
            len = $urandom_range(1, hdr_bytes + 1);
            for (int i = 0; i < len; i++) begin
               send_glyph_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                               i == len - 1);
            end
         end
         sent += len;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'd0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = 32'd0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_layout_records();
      test_register_extremes();
      test_midrecord_register_change();
      test_random_records(35, 50, 330);
      test_random_records(50, 35, 330);
      test_random_records(0, 0, 330);

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/gru_pkg.sv
rtl/glyph_record_unpacker_unit.sv
tb/glyph_record_unpacker_unit_tb.sv
